>>> rtl/core/bzr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_pkg: shared types and constants of the buzzer tone sequencer
// Opcodes, register indexes and the command word passed to the back end.
// ----------------------------------------------------------------------------
package bzr_pkg;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_NOTE    = 3'd1;
    localparam logic [2:0] OP_SILENCE = 3'd2;
    localparam logic [2:0] OP_BEEP    = 3'd3;
    localparam logic [2:0] OP_ALARM   = 3'd4;

    localparam logic [1:0] REG_TONE  = 2'd0;
    localparam logic [1:0] REG_DUTY  = 2'd1;
    localparam logic [1:0] REG_CLOCK = 2'd2;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_TWO  = 2'd1;
    localparam logic [1:0] MODE_NORM = 2'd2;

    localparam logic [17:0] RESET_PERIOD = 18'd181817;
    localparam logic [9:0]  NOTE_PRESCALE = 10'd999;

    // Reciprocal of 255 scaled by 2^34, rounded up. Exact for products below 2^26.
    localparam logic [26:0] RECIP_255 = 27'd67372037;

    // Classified command handed from front to back.
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] freq;
        logic [7:0]  duty;
        logic [30:0] dur;
        logic [1:0]  mode;
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/core/buzzer_tone_alarm_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buzzer_tone_alarm_sequencer: PWM buzzer tone and alarm sequencer
// Top level: register file, command queue and execution back end.
// ----------------------------------------------------------------------------
// Every accepted item yields one result with the timer setting now in effect.
// Ticks and commands that change no tone offer their result once the back end
// has taken them from the queue; an item that plays a note first passes the
// 18-step period divider, a multiply state for period times duty and a
// reciprocal multiply that divides by 255. A two-entry queue lets items be
// taken while a result waits.
module buzzer_tone_alarm_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [15:0] i_frequency_hz,
    input  wire logic [7:0]  i_duty_level,
    input  wire logic [30:0] i_duration_ms,
    input  wire logic [1:0]  i_requested_mode,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [17:0]      o_period_count,
    output logic [17:0]      o_compare_count,
    output logic [9:0]       o_prescale_count,
    output logic [1:0]       o_alarm_mode,
    output logic             o_timer_active
);
    logic [15:0]   r_tone;
    logic [7:0]    r_duty;
    logic [16:0]   r_clk;
    bzr_pkg::t_cmd w_in, w_q;
    logic          w_qv, w_take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone <= 16'd2700;
            r_duty <= 8'd128;
            r_clk <= 17'd80000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bzr_pkg::REG_TONE:  r_tone <= i_cfg_data[15:0];
                bzr_pkg::REG_DUTY:  r_duty <= i_cfg_data[7:0];
                bzr_pkg::REG_CLOCK: r_clk <= i_cfg_data;
                default:            r_clk <= r_clk;
            endcase
        end
    end

    assign w_in = '{op: i_opcode, freq: i_frequency_hz, duty: i_duty_level,
                    dur: i_duration_ms, mode: i_requested_mode};

    bzr_front u_front (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_cmd  (w_in),
        .o_valid(w_qv),
        .i_take (w_take),
        .o_cmd  (w_q)
    );

    bzr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_qv),
        .o_take      (w_take),
        .i_cmd       (w_q),
        .i_alarm_tone(r_tone),
        .i_alarm_duty(r_duty),
        .i_clock_khz (r_clk),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_period    (o_period_count),
        .o_compare   (o_compare_count),
        .o_prescale  (o_prescale_count),
        .o_mode      (o_alarm_mode),
        .o_active    (o_timer_active)
    );

    // The prescaler only ever holds zero or the note value.
    a_presc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_prescale_count == 10'd0) || (o_prescale_count == 10'd999))
        else $error("prescaler out of range");
    // The queue only stalls its input while it holds an item.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_qv)
        else $error("stall with empty queue");
endmodule
`default_nettype wire

>>> rtl/core/bzr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_front: input acceptance and two-entry command queue
// Accepts items and buffers them until the back end takes them.
// ----------------------------------------------------------------------------
module bzr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire bzr_pkg::t_cmd i_cmd,
    output logic               o_valid,
    input  wire logic          i_take,
    output bzr_pkg::t_cmd      o_cmd
);
    bzr_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_cmd   = r_q[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/bzr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_div: serial restoring divider
// Divides an 18-bit numerator by a 16-bit divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bzr_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [17:0] i_num,
    input  wire logic [15:0] i_den,
    output logic             o_done,
    output logic [17:0]      o_quot
);
    logic [17:0] r_quot;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_trial;
    logic [17:0] w_diff;

    assign w_trial = {r_rem[15:0], r_quot[17]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= 5'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd17) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem <= 17'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (!w_diff[17]) begin
                r_rem <= w_diff[16:0];
                r_quot <= {r_quot[16:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quot <= {r_quot[16:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/bzr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bzr_back: command execution and tone state
// Runs ticks and commands, computes period and compare, and holds a result.
// ----------------------------------------------------------------------------
module bzr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_take,
    input  wire bzr_pkg::t_cmd i_cmd,
    input  wire logic [15:0]   i_alarm_tone,
    input  wire logic [7:0]    i_alarm_duty,
    input  wire logic [16:0]   i_clock_khz,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [17:0]        o_period,
    output logic [17:0]        o_compare,
    output logic [9:0]         o_prescale,
    output logic [1:0]         o_mode,
    output logic               o_active
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_CDIV = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state      r_state;
    logic [17:0] r_period, r_compare;
    logic [9:0]  r_prescale;
    logic [31:0] r_off;
    logic        r_run;
    logic [1:0]  r_mode;
    logic [7:0]  r_duty;
    logic [25:0] r_prod;

    logic        w_start, w_done;
    logic [17:0] w_quot;
    logic [15:0] w_freq;
    logic [17:0] w_p, w_p1;
    logic [52:0] w_scaled;
    logic [31:0] w_o;
    logic        w_note, w_sil, w_stop, w_zero, w_clrmode;
    logic        w_neg;

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_period = r_period;
    assign o_compare = r_compare;
    assign o_prescale = r_prescale;
    assign o_mode = r_mode;
    assign o_active = r_run;

    // Tick decode on the decremented offset.
    assign w_o = r_off - 32'd1;
    assign w_neg = w_o[31];
    always_comb begin
        w_note = 1'b0; w_sil = 1'b0; w_stop = 1'b0; w_zero = 1'b0; w_clrmode = 1'b0;
        unique case (r_mode)
            bzr_pkg::MODE_NONE: begin
                if (r_run && w_neg) begin w_sil = 1'b1; w_stop = 1'b1; end
            end
            bzr_pkg::MODE_TWO: begin
                if (!r_run) begin w_sil = 1'b1; w_clrmode = 1'b1; end
                else if (w_neg) begin
                    priority if ($signed(w_o) >= -32'sd100) w_note = 1'b1;
                    else if ($signed(w_o) >= -32'sd300) w_sil = 1'b1;
                    else if ($signed(w_o) >= -32'sd400) w_note = 1'b1;
                    else begin w_sil = 1'b1; w_stop = 1'b1; end
                end
            end
            bzr_pkg::MODE_NORM: begin
                if (!r_run) begin w_sil = 1'b1; w_clrmode = 1'b1; end
                else if (w_neg) begin
                    priority if ($signed(w_o) >= -32'sd50) w_note = 1'b1;
                    else if ($signed(w_o) >= -32'sd100) w_sil = 1'b1;
                    else if ($signed(w_o) >= -32'sd150) w_note = 1'b1;
                    else if ($signed(w_o) >= -32'sd200) w_sil = 1'b1;
                    else if ($signed(w_o) >= -32'sd250) w_note = 1'b1;
                    else if ($signed(w_o) >= -32'sd300) w_sil = 1'b1;
                    else if ($signed(w_o) < -32'sd999) w_zero = 1'b1;
                    else w_note = 1'b0;
                end
            end
            default: begin w_sil = 1'b1; w_clrmode = 1'b1; w_stop = 1'b1; end
        endcase
    end

    assign w_freq = (i_cmd.op == bzr_pkg::OP_TICK) ? i_alarm_tone : i_cmd.freq;
    assign w_start = o_take && (w_freq != 16'd0) &&
        ((i_cmd.op == bzr_pkg::OP_NOTE) || (i_cmd.op == bzr_pkg::OP_BEEP) ||
         ((i_cmd.op == bzr_pkg::OP_TICK) && w_note));
    assign w_p = w_quot - 18'd1;
    assign w_p1 = r_period + 18'd1;

    // Divide by 255 as a multiplication by its scaled reciprocal.
    assign w_scaled = {27'd0, r_prod} * {26'd0, bzr_pkg::RECIP_255};

    bzr_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_num  ({1'b0, i_clock_khz}),
        .i_den  (w_freq),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_period <= bzr_pkg::RESET_PERIOD;
            r_compare <= 18'd0;
            r_prescale <= 10'd0;
            r_off <= 32'd0;
            r_run <= 1'b0;
            r_mode <= bzr_pkg::MODE_NONE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_state <= w_start ? S_DIV : S_OUT;
                        r_duty <= (i_cmd.op == bzr_pkg::OP_TICK) ? i_alarm_duty
                                                                 : i_cmd.duty;
                        unique case (i_cmd.op)
                            bzr_pkg::OP_TICK: begin
                                r_off <= w_zero ? 32'd0 : w_o;
                                if (w_sil) r_compare <= 18'd0;
                                if (w_stop) r_run <= 1'b0;
                                if (w_clrmode) r_mode <= bzr_pkg::MODE_NONE;
                            end
                            bzr_pkg::OP_SILENCE: r_compare <= 18'd0;
                            bzr_pkg::OP_BEEP: begin
                                r_off <= {1'b0, i_cmd.dur};
                                r_run <= 1'b1;
                                r_mode <= bzr_pkg::MODE_NONE;
                            end
                            bzr_pkg::OP_ALARM: begin
                                r_mode <= i_cmd.mode;
                                r_run <= 1'b1;
                                r_off <= 32'd0;
                            end
                            default: r_run <= r_run;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_done) begin
                        if (w_p != r_period) begin
                            r_period <= w_p;
                            r_prescale <= bzr_pkg::NOTE_PRESCALE;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= w_p1 * r_duty;
                    r_state <= S_CDIV;
                end
                S_CDIV: begin
                    // The quotient by 255 lands in the compare register.
                    r_compare <= w_scaled[51:34];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
